FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked at the sampled edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pmct_pkg.sv
// Types and constants for the pausable minute countdown timer.
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

   localparam int unsigned QUOT_W = 10;   // minutes_left width
   localparam int unsigned REM_W  = 46;   // stored remaining nanoseconds
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned ROUND_STAGES = 2;   // estimate, then correction

   localparam logic [63:0] NS_PER_MIN = 64'd60_000_000_000;
   localparam logic [63:0] REMAIN_CAP = 64'd61_380_000_000_000;
   localparam logic [9:0]  MAX_MINUTES_RESET = 10'd99;

   // one minute is MIN_ODD << MIN_POW2 nanoseconds
   localparam int unsigned      MIN_POW2 = 11;
   localparam int unsigned      ODD_W    = REM_W - MIN_POW2;
   localparam logic [ODD_W-1:0] MIN_ODD  = 35'd29_296_875;
   localparam logic [REM_W-1:0] MIN_NS   = 46'd60_000_000_000;

   // minute rounding: ceil(x / one minute) = floor((x + CEIL_BIAS) / one minute),
   // estimated from the upper bits times floor(2^56 / one minute)
   localparam logic [REM_W-1:0]   CEIL_BIAS = 46'd59_999_999_999;
   localparam int unsigned        EST_SHIFT = 20;
   localparam int unsigned        RECIP_W   = 21;
   localparam int unsigned        PROD_W    = 46;
   localparam int unsigned        EST_POS   = 36;
   localparam logic [RECIP_W-1:0] MIN_RECIP = 21'd1_200_959;

   // register index (paddr above the byte offset)
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_MINUTES = '0;

   // commands
   localparam logic [3:0] CMD_UP             = 4'd0;
   localparam logic [3:0] CMD_DOWN           = 4'd1;
   localparam logic [3:0] CMD_TOGGLE         = 4'd2;
   localparam logic [3:0] CMD_UPDATE         = 4'd3;
   localparam logic [3:0] CMD_RESET          = 4'd4;
   localparam logic [3:0] CMD_RESET_FEEDBACK = 4'd5;
   localparam logic [3:0] CMD_SHOW_EXPIRED   = 4'd6;
   localparam logic [3:0] CMD_CLEAR_FEEDBACK = 4'd7;
   localparam logic [3:0] CMD_SOUND_DONE     = 4'd8;

   // run status
   localparam logic [1:0] ST_EMPTY   = 2'd0;
   localparam logic [1:0] ST_SET     = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_PAUSED  = 2'd3;

   // feedback / display codes
   localparam logic [1:0] FB_EMPTY   = 2'd0;
   localparam logic [1:0] FB_ACTIVE  = 2'd1;
   localparam logic [1:0] FB_RESET   = 2'd2;
   localparam logic [1:0] FB_EXPIRED = 2'd3;

   // toggle outcomes
   localparam logic [2:0] TR_NONE    = 3'd0;
   localparam logic [2:0] TR_STARTED = 3'd1;
   localparam logic [2:0] TR_EXPIRED = 3'd2;
   localparam logic [2:0] TR_PAUSED  = 3'd3;
   localparam logic [2:0] TR_RESUMED = 3'd4;

   // sound_done outcomes
   localparam logic [1:0] FA_NONE   = 2'd0;
   localparam logic [1:0] FA_ARM    = 2'd1;
   localparam logic [1:0] FA_CANCEL = 2'd2;

   typedef struct packed {
      logic              accepted;
      logic [2:0]        transition;
      logic [1:0]        feedback_action;
      logic [1:0]        display_code;
      logic [REM_W-1:0]  remaining;
      logic [REM_W-1:0]  round_sum;   // remaining plus one minute less one ns
      logic [QUOT_W-1:0] minutes;
   } pmct_item_type;

endpackage

`default_nettype wire

FILE: design/pmct_csr.sv
// Configuration register block: max_minutes behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module pmct_csr
   import pmct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output logic      [9:0]            max_minutes
);

   logic [9:0] max_minutes_ff;
   logic       sel_max;
   logic       wr_en;

   assign sel_max    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MAX_MINUTES);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_minutes_ff <= MAX_MINUTES_RESET;
      end else if (wr_en && sel_max) begin
         max_minutes_ff <= csr_pwdata[9:0];
      end
   end

   assign csr_prdata  = sel_max ? {22'd0, max_minutes_ff} : 32'd0;
   assign max_minutes = max_minutes_ff;

endmodule

`default_nettype wire

FILE: design/pmct_core.sv
// Timer state and per-event step logic with its result register.
`timescale 1ns / 1ps
`default_nettype none

module pmct_core
   import pmct_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [3:0]    command,
   input  wire logic [63:0]   now_ns,
   input  wire logic          sound_ok,
   input  wire logic [9:0]    max_minutes,
   output logic               out_valid,
   input  wire logic          out_ready,
   output pmct_item_type      out_item
);

   logic [1:0]        status_ff,   status_in;
   logic [REM_W-1:0]  rem_ff,      rem_in;
   logic [63:0]       deadline_ff, deadline_in;
   logic [1:0]        fb_ff,       fb_in;
   // whole minutes stored; meaningful while empty or set
   logic [QUOT_W-1:0] count_ff,    count_in;
   logic              valid_ff;
   pmct_item_type     item_ff,     item_in;

   logic              accept;
   logic              expired;
   logic [63:0]       diff;
   logic [REM_W-1:0]  diff_cap;
   logic [63:0]       start_deadline;
   logic              can_adjust;
   logic              adj_ok;
   logic [QUOT_W-1:0] adj_count;
   logic [ODD_W-1:0]  adj_prod;
   logic [REM_W-1:0]  adj_rem;
   logic              acc;
   logic [2:0]        trans;
   logic [1:0]        fact;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   assign expired        = (now_ns >= deadline_ff);
   assign diff           = deadline_ff - now_ns;
   assign diff_cap       = (diff > REMAIN_CAP) ? REMAIN_CAP[REM_W-1:0] : diff[REM_W-1:0];
   assign start_deadline = now_ns + 64'(rem_ff);

   assign can_adjust = (status_ff == ST_EMPTY) || (status_ff == ST_SET);
   assign adj_ok     = can_adjust && ((command == CMD_UP) ? (count_ff < max_minutes)
                                                          : (count_ff != '0));
   assign adj_count  = (command == CMD_UP) ? count_ff + 1'b1 : count_ff - 1'b1;
   assign adj_prod   = ODD_W'(adj_count) * MIN_ODD;
   assign adj_rem    = {adj_prod, {MIN_POW2{1'b0}}};

   always_comb begin
      status_in   = status_ff;
      rem_in      = rem_ff;
      deadline_in = deadline_ff;
      fb_in       = fb_ff;
      count_in    = count_ff;
      acc         = 1'b0;
      trans       = TR_NONE;
      fact        = FA_NONE;
      unique case (command)
         CMD_UP, CMD_DOWN: begin
            if (adj_ok) begin
               acc         = 1'b1;
               count_in    = adj_count;
               rem_in      = adj_rem;
               deadline_in = '0;
               status_in   = (adj_count != '0) ? ST_SET : ST_EMPTY;
               fb_in       = FB_EMPTY;
            end
         end
         CMD_TOGGLE: begin
            if (rem_ff != '0) begin
               unique case (status_ff)
                  ST_SET, ST_PAUSED: begin
                     deadline_in = start_deadline;
                     status_in   = ST_RUNNING;
                     trans       = (status_ff == ST_SET) ? TR_STARTED : TR_RESUMED;
                  end
                  ST_RUNNING: begin
                     if (expired) begin
                        status_in   = ST_EMPTY;
                        rem_in      = '0;
                        deadline_in = '0;
                        count_in    = '0;
                        trans       = TR_EXPIRED;
                     end else begin
                        rem_in      = diff_cap;
                        deadline_in = '0;
                        status_in   = ST_PAUSED;
                        trans       = TR_PAUSED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CMD_UPDATE: begin
            if (status_ff == ST_RUNNING) begin
               if (expired) begin
                  status_in   = ST_EMPTY;
                  rem_in      = '0;
                  deadline_in = '0;
                  count_in    = '0;
                  acc         = 1'b1;
               end else begin
                  rem_in = diff_cap;
               end
            end
         end
         CMD_RESET, CMD_SHOW_EXPIRED: begin
            status_in   = ST_EMPTY;
            rem_in      = '0;
            deadline_in = '0;
            count_in    = '0;
            fb_in       = (command == CMD_RESET) ? FB_EMPTY : FB_EXPIRED;
         end
         CMD_RESET_FEEDBACK: begin
            if (status_ff != ST_EMPTY) begin
               status_in   = ST_EMPTY;
               rem_in      = '0;
               deadline_in = '0;
               count_in    = '0;
               fb_in       = FB_RESET;
               acc         = 1'b1;
            end
         end
         CMD_CLEAR_FEEDBACK: begin
            fb_in = FB_EMPTY;
         end
         CMD_SOUND_DONE: begin
            if (fb_ff == FB_EXPIRED) begin
               if (sound_ok) begin
                  fb_in = FB_EMPTY;
                  fact  = FA_CANCEL;
               end else begin
                  fact  = FA_ARM;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      item_in                 = '0;
      item_in.accepted        = acc;
      item_in.transition      = trans;
      item_in.feedback_action = fact;
      item_in.display_code    = (status_in != ST_EMPTY) ? FB_ACTIVE : fb_in;
      item_in.remaining       = rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= ST_EMPTY;
         rem_ff      <= '0;
         deadline_ff <= '0;
         fb_ff       <= FB_EMPTY;
         count_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            status_ff   <= status_in;
            rem_ff      <= rem_in;
            deadline_ff <= deadline_in;
            fb_ff       <= fb_in;
            count_ff    <= count_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: design/pmct_div_stage.sv
// One stage of the minute rounding: reciprocal estimate or the final correction step.
`timescale 1ns / 1ps
`default_nettype none

module pmct_div_stage
   import pmct_pkg::*;
#(
   parameter bit CORRECT = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire pmct_item_type in_item,
   output logic               out_valid,
   input  wire logic          out_ready,
   output pmct_item_type      out_item
);

   logic          valid_ff;
   pmct_item_type item_ff, item_in;

   if (!CORRECT) begin : g_estimate
      logic [REM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;

      // ceiling taken as a floor; the upper bits times 2^56 / one minute land
      // on the quotient or one below it
      assign sum  = in_item.remaining + CEIL_BIAS;
      assign prod = PROD_W'(sum[REM_W-1:EST_SHIFT]) * PROD_W'(MIN_RECIP);

      always_comb begin
         item_in           = in_item;
         item_in.round_sum = sum;
         item_in.minutes   = prod[EST_POS +: QUOT_W];
      end
   end else begin : g_correct
      logic [ODD_W-1:0] base;
      logic [REM_W-1:0] excess;
      logic             carry;

      assign base   = ODD_W'(in_item.minutes) * MIN_ODD;
      assign excess = in_item.round_sum - {base, {MIN_POW2{1'b0}}};
      assign carry  = (excess >= MIN_NS);

      always_comb begin
         item_in         = in_item;
         item_in.minutes = in_item.minutes + QUOT_W'(carry);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: design/pausable_minute_countdown_timer.sv
// Top level of the pausable minute countdown timer.
//
// Events arrive on the req_ stream: req_tuser carries the command, req_tdata the
// current time in nanoseconds (bits 63:0) and the sound-finished flag (bit 64).
// Every accepted event yields exactly one result on the rsp_ stream, in order.
// The timer state is updated in the cycle the event is accepted; the result then
// passes through the step register and two rounding stages that turn the
// remaining time into whole minutes (reciprocal estimate, then one correction).
// Throughput: one event per cycle while rsp_tready is high; each of the three
// registers takes a new result whenever the one after it moves. Up to 3 results
// are held while rsp_tready is low; bubbles are squeezed out and req_tready only
// drops once all three hold a result. max_minutes is written through the csr_
// port (byte address 0); the user must do so only while no event is in flight,
// which the block does not enforce. Reset clears the timer to empty, the
// feedback code to none, max_minutes to 99 and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pausable_minute_countdown_timer
   import pmct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [71:0]           req_tdata,   // now_ns[63:0], sound_ok[64], zero pad
   input  wire logic [3:0]            req_tuser,   // command
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // accepted[0], transition[3:1], feedback_action[5:4], display_code[7:6],
   // minutes_left[17:8], remaining_time[63:18]
   output logic      [63:0]           rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   logic [9:0]    max_minutes;
   logic          stage_valid [ROUND_STAGES+1];
   logic          stage_ready [ROUND_STAGES+1];
   pmct_item_type stage_item  [ROUND_STAGES+1];
   pmct_item_type result;

   pmct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_minutes (max_minutes)
   );

   pmct_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .command     (req_tuser),
      .now_ns      (req_tdata[63:0]),
      .sound_ok    (req_tdata[64]),
      .max_minutes (max_minutes),
      .out_valid   (stage_valid[0]),
      .out_ready   (stage_ready[0]),
      .out_item    (stage_item[0])
   );

   pmct_div_stage #(
      .CORRECT (1'b0)
   ) u_estimate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[0]),
      .in_ready  (stage_ready[0]),
      .in_item   (stage_item[0]),
      .out_valid (stage_valid[1]),
      .out_ready (stage_ready[1]),
      .out_item  (stage_item[1])
   );

   pmct_div_stage #(
      .CORRECT (1'b1)
   ) u_correct (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[1]),
      .in_ready  (stage_ready[1]),
      .in_item   (stage_item[1]),
      .out_valid (stage_valid[2]),
      .out_ready (stage_ready[2]),
      .out_item  (stage_item[2])
   );

   assign stage_ready[ROUND_STAGES] = rsp_tready;
   assign result                    = stage_item[ROUND_STAGES];
   assign rsp_tvalid                = stage_valid[ROUND_STAGES];
   assign rsp_tdata                 = {result.remaining, result.minutes, result.display_code,
                                       result.feedback_action, result.transition,
                                       result.accepted};

endmodule

`default_nettype wire

FILE: design/pmct_checker.sv
// Port-level checks on the timer result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pmct_checker
   import pmct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata
);

   logic [QUOT_W-1:0] mins;
   logic [REM_W-1:0]  rem;
   logic [1:0]        disp;
   logic [2:0]        trans;
   logic [1:0]        fact;
   logic              acc;

   assign acc   = rsp_tdata[0];
   assign trans = rsp_tdata[3:1];
   assign fact  = rsp_tdata[5:4];
   assign disp  = rsp_tdata[7:6];
   assign mins  = rsp_tdata[17:8];
   assign rem   = rsp_tdata[63:18];

   // rounding up: zero minutes exactly when nothing is left
   `ASSERT_ALWAYS(a_minutes_zero, clock, reset, !rsp_tvalid || ((mins == '0) == (rem == '0)), "minutes_left disagrees with remaining_time")

   // an idle timer holds no time
   `ASSERT_ALWAYS(a_idle_empty, clock, reset, !rsp_tvalid || disp == FB_ACTIVE || rem == '0, "time left while display shows no active timer")

   // a toggle outcome excludes the other per-command answers
   `ASSERT_ALWAYS(a_one_answer, clock, reset, !rsp_tvalid || trans == TR_NONE || (!acc && fact == FA_NONE), "toggle result mixed with another answer")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind pausable_minute_countdown_timer pmct_checker u_checker (.*);

`default_nettype wire
